// File: rtl/core/mes_pkg.sv
package mes_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_MOVE,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic do_insert;
    logic set_full;
    logic set_empty;
    logic scan_begin;
    logic scan_step;
    logic do_move;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_extract;
    logic full;
    logic empty;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/mes_ram.sv
module mes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/mes_ctrl.sv
module mes_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  mes_pkg::stat_t stat,
  output mes_pkg::cmd_t  cmd
);
  import mes_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_extract && !stat.empty) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_RESP;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      S_EXEC: begin
        if (stat.is_extract) begin
          cmd.set_empty  = stat.empty;
          cmd.scan_begin = !stat.empty;
        end else begin
          cmd.set_full  = stat.full;
          cmd.do_insert = !stat.full;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_MOVE: begin
        cmd.do_move = 1'b1;
      end
      S_RESP: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/mes_dp.sv
module mes_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mes_pkg::cmd_t                      cmd,
  output mes_pkg::stat_t                     stat,
  input  logic [mes_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [mes_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [mes_pkg::STATUS_W-1:0]       m_tuser
);
  import mes_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic               opcode;
  logic [VALUE_W-1:0] value;
  logic [CW-1:0]      count;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      last_idx;
  logic [VALUE_W-1:0] best_val;
  logic [AW-1:0]      best_idx;
  logic [VALUE_W-1:0] last_val;
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_min;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;
  logic               take_new;

  // Entries are kept packed in slots 0 to count-1; an extract refills the
  // freed slot with the entry from the top slot.
  mes_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign last_idx  = AW'(count - CW'(1));
  assign ram_we    = cmd.do_insert || cmd.do_move;
  assign ram_waddr = cmd.do_move ? best_idx : AW'(count);
  assign ram_wdata = cmd.do_move ? last_val : value;
  assign ram_raddr = cmd.scan_begin ? '0 : AW'(idx + AW'(1));

  // Read data is registered, so in a scan step it belongs
  // to slot idx. Ties keep the earlier slot.
  assign take_new = (idx == '0) || ($signed(ram_rdata) < $signed(best_val));

  assign stat.is_extract = (opcode == OP_EXTRACT);
  assign stat.full       = (count == CW'(CAPACITY));
  assign stat.empty      = (count == '0);
  assign stat.scan_done  = (idx == last_idx);
  assign stat.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      opcode <= s_tuser;
      value  <= s_tdata;
    end
    if (cmd.scan_begin) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx      <= AW'(idx + AW'(1));
      last_val <= ram_rdata;
      if (take_new) begin
        best_val <= ram_rdata;
        best_idx <= idx;
      end
    end
    if (cmd.do_insert) begin
      res_status <= ST_OK;
      res_min    <= '0;
    end else if (cmd.set_full) begin
      res_status <= ST_FULL;
      res_min    <= '0;
    end else if (cmd.set_empty) begin
      res_status <= ST_EMPTY;
      res_min    <= '0;
    end else if (cmd.do_move) begin
      res_status <= ST_OK;
      res_min    <= best_val;
    end
    if (cmd.load_out) begin
      m_tuser <= res_status;
      m_tdata <= {3'b000, COUNT_W'(count), res_min};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.do_insert) begin
        count <= CW'(count + CW'(1));
      end else if (cmd.do_move) begin
        count <= CW'(count - CW'(1));
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |-> !stat.full)
    else $error("insert written into a full store");

  a_move_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.do_move |-> !stat.empty)
    else $error("extract removed from an empty store");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> ({1'b0, idx} < (AW + 1)'(count)))
    else $error("scan index beyond stored entries");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over an untaken result");

endmodule

// File: rtl/core/min_extract_store_unit.sv
// Min-extract store: a bounded multiset of signed 32-bit values.
// An insert request (s_tuser = 0) stores s_tdata in the next free slot; an
// extract request (s_tuser = 1) removes one smallest value and returns it.
// Every request gives exactly one result on the master side, with a status
// in m_tuser (ok, extract on empty store, insert on full store dropped),
// the extracted value (zero unless an ok extract) and the entry count after
// the request in m_tdata.
// One request is worked on at a time; s_tready is high only while idle.
// An insert, or an extract on an empty store, goes from acceptance through
// the execute state to the response state. An extract on a non-empty store
// also passes the scan and move states: the RAM read port is walked one entry
// per cycle with one signed comparator, then the top entry fills the slot.
// The result sits in an output register, and the block returns to idle as
// soon as that register is loaded. If the receiver stalls while a result
// is still held, the next request finishes its work and waits until the
// register is free.
// Reset empties the store at once (the count goes to zero); no clearing
// pass is needed.
module min_extract_store_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic        s_tuser,   // opcode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // min_value[31:0], count[36:32], zero pad
  output logic [1:0]  m_tuser    // status[1:0]
);
  import mes_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mes_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: tb/sv/min_store_checker.sv
`timescale 1ns / 100ps

module min_store_checker #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic        s_tuser,   // opcode[0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // min_value[31:0], count[36:32], zero pad
  input  logic [1:0]  m_tuser,   // status[1:0]
  output int          errors,
  output int          pending
);
  import mes_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  min_value;
    logic [COUNT_W-1:0]  count;
  } store_result_t;

  logic signed [VALUE_W-1:0] slot_value [CAPACITY];
  logic                      slot_used  [CAPACITY];
  int                        used_count;
  store_result_t             expected_results [$];

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_value[i] = '0;
      slot_used[i]  = 1'b0;
    end
    used_count = 0;
    errors     = 0;
    pending    = 0;
  end

  // Applies one request to the shadow store and returns the result it must give.
  function automatic store_result_t apply_store_op(logic op, logic signed [VALUE_W-1:0] value);
    store_result_t res;
    int            pick;
    res.status    = ST_OK;
    res.min_value = '0;
    pick          = -1;
    if (op == OP_INSERT) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!slot_used[i] && pick < 0) begin
          pick = i;
        end
      end
      if (pick < 0) begin
        res.status = ST_FULL;
      end else begin
        slot_used[pick]  = 1'b1;
        slot_value[pick] = value;
        used_count++;
      end
    end else begin
      // Strict less-than keeps the lowest slot among equal minima.
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_used[i] && (pick < 0 || slot_value[i] < slot_value[pick])) begin
          pick = i;
        end
      end
      if (pick < 0) begin
        res.status = ST_EMPTY;
      end else begin
        slot_used[pick] = 1'b0;
        res.min_value   = slot_value[pick];
        used_count--;
      end
    end
    res.count = COUNT_W'(used_count);
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    store_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual status %0d",
                 $time, m_tuser);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("min_value", want.min_value, m_tdata[31:0]);
        check_field("count", 32'(want.count), 32'(m_tdata[36:32]));
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      expected_results.push_back(apply_store_op(s_tuser, s_tdata));
    end
    pending = expected_results.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mes_pkg::*;

  localparam int CAPACITY        = 16;
  localparam int RANDOM_REQUESTS = 1500;
  localparam int STALL_LIMIT     = 2000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        s_tuser  = OP_INSERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  int errors;
  int pending;
  int idle_cycles = 0;
  int burst_left  = 0;
  int ready_mode  = 0;
  int ready_timer = 0;

  always #5 clk = ~clk;

  min_extract_store_unit #(.CAPACITY(CAPACITY)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  min_store_checker #(.CAPACITY(CAPACITY)) u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  // The receiver switches between always ready, light and heavy random
  // stalls, and a fixed periodic pattern.
  always @(posedge clk) begin
    if (ready_timer == 0) begin
      ready_mode  <= $urandom_range(0, 3);
      ready_timer <= $urandom_range(20, 300);
    end else begin
      ready_timer <= ready_timer - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 99) < 70);
      2: m_tready <= ($urandom_range(0, 99) < 25);
      default: m_tready <= (ready_timer % 7) > 2;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Full-range values, with a share of small values so that equal
  // minima are common, and values at or near both ends of the range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 8) - 4;
      7:          return 32'h8000_0000 + $urandom_range(0, 3);
      8:          return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default:    return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  // Presents one request, waits for it to be taken, then either keeps the
  // burst going or opens a gap.
  task automatic issue_request(input logic op, input logic [31:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap        = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int phase_left;
    int insert_pct;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extract on an empty store, then fill it with the range ends and a
    // repeated minimum, overflow it once and take a few minima back out.
    issue_request(OP_EXTRACT, 32'hFFFF_FFFF);
    issue_request(OP_INSERT, 32'h7FFF_FFFF);
    issue_request(OP_INSERT, 32'h8000_0000);
    issue_request(OP_INSERT, 32'h0000_0000);
    issue_request(OP_INSERT, 32'hFFFF_FFFF);
    issue_request(OP_INSERT, 32'h0000_0001);
    issue_request(OP_INSERT, 32'h8000_0000);
    for (int i = 0; i < CAPACITY - 6; i++) begin
      issue_request(OP_INSERT, $urandom);
    end
    issue_request(OP_INSERT, 32'h1234_5678);
    repeat (3) issue_request(OP_EXTRACT, $urandom);
    drain_results();

    // Phases lean toward inserts or extracts, or keep them balanced, so the store
    // swings between full and empty.
    phase_left = 0;
    insert_pct = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 15;
        endcase
        if (n == 0 || $urandom_range(0, 3) == 0) begin
          drain_results();
        end
      end
      phase_left--;
      issue_request(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT,
                    pick_value());
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
